>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent assertions clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define MD5_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define MD5_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define MD5_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Sequencer states, round constants and round helper functions.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND_A,
    ST_ROUND_B,
    ST_CHAIN,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } md5_state_e;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_PADX,
    MODE_LEN
  } md5_mode_e;

  localparam int unsigned CountW = 61;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] K_ADD [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] K_ROT [0:15] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] wide;
    wide = {v, v} << s;
    return wide[63:32];
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0:    return lo;
      2'd1:    return 4'((lo << 2) + lo + 4'd1);
      2'd2:    return 4'((lo << 1) + lo + 4'd5);
      default: return 4'((lo << 3) - lo);
    endcase
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] phase, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    unique case (phase)
      2'd0:    return (b & c) | (~b & d);
      2'd1:    return (b & d) | (c & ~d);
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

endpackage

>>> src/md5_message_digest.sv
// ----------------------------------------------------------------------------
// MD5 message digest
// Hashes a byte stream and returns the digest as four 32-bit words.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: data_byte; tuser: byte_valid; tlast: final_req
// m_axis    out        tdata: digest_word; tuser: word_index; tlast: last_word
//
// A request that does not complete a 64-byte block is stored in ST_IDLE.
// Each block compression runs 64 rounds, each through ST_ROUND_A and
// ST_ROUND_B on the shared round adder, then folds the result into the chain.
// A final request adds a padding step in ST_PAD, one compression, a second
// compression with a setup step in ST_LEN when fewer than nine bytes are
// free, and four output words that wait on m_axis_tready.
// Reset loads the initial chaining words; the block is ready right after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,  // [0] byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,  // [1:0] word_index
  output logic        m_axis_tlast
);

  md5_pkg::md5_state_e state_q, state_d;
  md5_pkg::md5_mode_e  mode_q, mode_d;
  logic                final_q, final_d;
  logic [5:0]          round_q, round_d;
  logic [1:0]          idx_q, idx_d;
  logic [md5_pkg::CountW-1:0] count_q, count_d;
  logic [31:0]         chain_q [4];
  logic [31:0]         chain_d [4];
  logic [31:0]         work_q [4];
  logic [31:0]         work_d [4];
  logic [31:0]         store_q [16];
  logic [31:0]         store_d [16];
  logic [31:0]         sum_q, sum_d;

  logic [5:0]          used;
  logic [31:0]         len_lo;
  logic [31:0]         len_hi;
  logic [31:0]         f_val;
  logic [3:0]          g_idx;
  logic [4:0]          rot;

  logic                digest_done;
  logic                idle_clear;
  logic                in_chain;
  logic                in_round_a;
  logic                last_round;
  logic                round_step;
  logic [5:0]          round_inc;

  assign used   = count_q[5:0];
  assign len_lo = {count_q[28:0], 3'b000};
  assign len_hi = count_q[60:29];
  assign f_val  = md5_pkg::round_fn(round_q[5:4], work_q[1], work_q[2], work_q[3]);
  assign g_idx  = md5_pkg::msg_index(round_q);
  assign rot    = md5_pkg::K_ROT[{round_q[5:4], round_q[1:0]}];

  assign s_axis_tready = (state_q == md5_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == md5_pkg::ST_OUT);
  assign m_axis_tdata  = chain_q[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 2'd3);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    final_d = final_q;
    round_d = round_q;
    idx_d   = idx_q;
    count_d = count_q;
    chain_d = chain_q;
    work_d  = work_q;
    store_d = store_q;
    sum_d   = sum_q;

    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          final_d = s_axis_tlast;
          if (s_axis_tuser[0]) begin
            store_d[used[5:2]][8*used[1:0] +: 8] = s_axis_tdata;
            count_d = count_q + md5_pkg::CountW'(1);
          end
          if (s_axis_tuser[0] && (used == md5_pkg::LAST_POS)) begin
            mode_d  = md5_pkg::MODE_DATA;
            work_d  = chain_q;
            round_d = '0;
            state_d = md5_pkg::ST_ROUND_A;
          end else if (s_axis_tlast) begin
            state_d = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_ROUND_A: begin
        sum_d   = f_val + work_q[0] + md5_pkg::K_ADD[round_q] + store_q[g_idx];
        state_d = md5_pkg::ST_ROUND_B;
      end
      md5_pkg::ST_ROUND_B: begin
        work_d[0] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = work_q[1];
        work_d[1] = work_q[1] + md5_pkg::rotl32(sum_q, rot);
        round_d   = round_q + 6'd1;
        state_d   = (round_q == md5_pkg::LAST_POS) ? md5_pkg::ST_CHAIN : md5_pkg::ST_ROUND_A;
      end
      md5_pkg::ST_CHAIN: begin
        for (int i = 0; i < 4; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        unique case (mode_q)
          md5_pkg::MODE_DATA: state_d = final_q ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
          md5_pkg::MODE_PADX: state_d = md5_pkg::ST_LEN;
          default:            state_d = md5_pkg::ST_OUT;
        endcase
      end
      md5_pkg::ST_PAD: begin
        for (int w = 0; w < 16; w++) begin
          for (int b = 0; b < 4; b++) begin
            if (6'(w * 4 + b) == used) begin
              store_d[w][8*b +: 8] = md5_pkg::PAD_BYTE;
            end else if (6'(w * 4 + b) > used) begin
              store_d[w][8*b +: 8] = 8'h00;
            end
          end
        end
        if (used < md5_pkg::LEN_POS) begin
          store_d[14] = len_lo;
          store_d[15] = len_hi;
          mode_d      = md5_pkg::MODE_LEN;
        end else begin
          mode_d      = md5_pkg::MODE_PADX;
        end
        work_d  = chain_q;
        round_d = '0;
        state_d = md5_pkg::ST_ROUND_A;
      end
      md5_pkg::ST_LEN: begin
        for (int w = 0; w < 14; w++) begin
          store_d[w] = '0;
        end
        store_d[14] = len_lo;
        store_d[15] = len_hi;
        mode_d      = md5_pkg::MODE_LEN;
        work_d      = chain_q;
        round_d     = '0;
        state_d     = md5_pkg::ST_ROUND_A;
      end
      md5_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            chain_d[0] = md5_pkg::IV_A;
            chain_d[1] = md5_pkg::IV_B;
            chain_d[2] = md5_pkg::IV_C;
            chain_d[3] = md5_pkg::IV_D;
            count_d    = '0;
            final_d    = 1'b0;
            state_d    = md5_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = md5_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= md5_pkg::ST_IDLE;
      mode_q     <= md5_pkg::MODE_DATA;
      final_q    <= 1'b0;
      round_q    <= '0;
      idx_q      <= '0;
      count_q    <= '0;
      chain_q[0] <= md5_pkg::IV_A;
      chain_q[1] <= md5_pkg::IV_B;
      chain_q[2] <= md5_pkg::IV_C;
      chain_q[3] <= md5_pkg::IV_D;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      final_q <= final_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    store_q <= store_d;
    sum_q   <= sum_d;
  end

  assign digest_done = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign idle_clear  = s_axis_tready && (count_q == '0);
  assign in_chain    = (state_q == md5_pkg::ST_CHAIN);
  assign in_round_a  = (state_q == md5_pkg::ST_ROUND_A);
  assign last_round  = (state_q == md5_pkg::ST_ROUND_B) && (round_q == 6'd63);
  assign round_step  = (state_q == md5_pkg::ST_ROUND_B) && (round_q != 6'd63);
  assign round_inc   = round_q + 6'd1;

  `MD5_ASSERT(a_sides_exclusive, !(s_axis_tready && m_axis_tvalid), "Both sides open")
  `MD5_ASSERT_NXT(a_idle_after_digest, digest_done, idle_clear, "Not cleared after digest")
  `MD5_ASSERT_IMP(a_chain_after_rounds, in_chain, $past(last_round), "Early chain update")
  `MD5_ASSERT_NXT(a_round_advance, round_step, in_round_a && (round_q == $past(round_inc)), "Bad step")

endmodule
